// ----- hdl/pin_change_interrupt_dispatcher_macros.svh -----
// ---------------------------------------------------------------------------
// Pin-change interrupt dispatcher assertion macros
// Clocked assertions on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef PIN_CHANGE_INTERRUPT_DISPATCHER_MACROS_SVH
`define PIN_CHANGE_INTERRUPT_DISPATCHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PCID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcid_pkg.sv -----
// ---------------------------------------------------------------------------
// pcid_pkg
// Types, codes and defaults shared by the pin-change interrupt dispatcher.
// ---------------------------------------------------------------------------
package pcid_pkg;

  localparam int DEF_PINS_PER_GROUP = 8;
  localparam int DEF_NUM_GROUPS     = 3;
  localparam int DEF_QUEUE_DEPTH    = 2;

  localparam int ENABLE_W  = 24;
  localparam int LEVELS_W  = 8;
  localparam int PIN_W     = 5;
  localparam int GRP_IDX_W = 3;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_SERVICE = 2'd1;
  localparam logic [1:0] CMD_CAPTURE = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          group;
    logic [LEVELS_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] dispatched_pin;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CAPTURE,
    OP_SERVICE
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [GRP_IDX_W-1:0] grp;
    logic [LEVELS_W-1:0]  levels;
  } cmd_entry_t;

  typedef struct packed {
    logic       push;
    cmd_entry_t entry;
  } push_req_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } q_head_t;

  typedef enum logic {
    ST_IDLE,
    ST_SERVICE
  } back_state_t;

endpackage

// ----- hdl/pcid_front.sv -----
// ---------------------------------------------------------------------------
// pcid_front
// Accepts, decodes commands; drops unused and bad-group sample/capture ones.
// ---------------------------------------------------------------------------
module pcid_front #(
  parameter int NUM_GROUPS = pcid_pkg::DEF_NUM_GROUPS
) (
  input  logic                start,
  input  pcid_pkg::in_item_t  item,
  input  logic                full,
  output logic                busy,
  output pcid_pkg::push_req_t push_req
);
  import pcid_pkg::*;

  logic accept;
  logic grp_ok;

  assign busy   = full;
  assign accept = start && !full;
  assign grp_ok = ({2'b00, item.group} < 4'(NUM_GROUPS));

  always_comb begin
    push_req.push         = 1'b0;
    push_req.entry.op     = OP_SAMPLE;
    push_req.entry.grp    = GRP_IDX_W'(item.group);
    push_req.entry.levels = item.pin_levels;
    unique case (item.cmd)
      CMD_SAMPLE: begin
        push_req.entry.op = OP_SAMPLE;
        push_req.push     = accept && grp_ok;
      end
      CMD_CAPTURE: begin
        push_req.entry.op = OP_CAPTURE;
        push_req.push     = accept && grp_ok;
      end
      CMD_SERVICE: begin
        push_req.entry.op = OP_SERVICE;
        push_req.push     = accept;
      end
      default: push_req.push = 1'b0;
    endcase
  end

endmodule

// ----- hdl/pcid_queue.sv -----
// ---------------------------------------------------------------------------
// pcid_queue
// Small command FIFO between the front and back ends (depth of two or more).
// ---------------------------------------------------------------------------
module pcid_queue #(
  parameter int DEPTH = pcid_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  pcid_pkg::push_req_t push_req,
  output logic                full,
  input  logic                pop,
  output pcid_pkg::q_head_t   head
);
  import pcid_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_entry_t    entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_req.push) begin
      entries[wr_ptr] <= push_req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_req.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_req.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push_req.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/pcid_back.sv -----
// ---------------------------------------------------------------------------
// pcid_back
// Holds levels, pending flags; applies samples/captures, runs service scans.
// ---------------------------------------------------------------------------
`include "pin_change_interrupt_dispatcher_macros.svh"

module pcid_back #(
  parameter int PINS_PER_GROUP = pcid_pkg::DEF_PINS_PER_GROUP,
  parameter int NUM_GROUPS     = pcid_pkg::DEF_NUM_GROUPS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pcid_pkg::q_head_t              head,
  output logic                           pop,
  input  logic [pcid_pkg::ENABLE_W-1:0]  enable_mask,
  output logic                           result_valid,
  output pcid_pkg::out_item_t            result
);
  import pcid_pkg::*;

  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int KW    = (PINS_PER_GROUP > 1) ? $clog2(PINS_PER_GROUP) : 1;
  localparam int TOTAL = NUM_GROUPS * PINS_PER_GROUP;
  localparam int NUM_W = $clog2(TOTAL) + 1;

  typedef logic [PINS_PER_GROUP-1:0] grp_bits_t;

  back_state_t     state;
  back_state_t     state_next;
  logic [GW-1:0]   cur_g;
  logic [GW-1:0]   cur_g_next;
  grp_bits_t       pending  [NUM_GROUPS];
  grp_bits_t       last_lv  [NUM_GROUPS];
  grp_bits_t       en_grp   [NUM_GROUPS];
  grp_bits_t       new_lv;
  logic [NUM_GROUPS-1:0] group_any;
  logic [NUM_GROUPS-1:0] later;

  logic [GW-1:0]   rd_g;
  grp_bits_t       sel_pend;
  grp_bits_t       sel_lv;
  grp_bits_t       sel_en;
  logic [KW-1:0]   pin_k;
  grp_bits_t       rest;
  logic [NUM_W-1:0] pin_num;

  logic            pend_we;
  logic            lv_we;
  grp_bits_t       pend_wdata;
  grp_bits_t       lv_wdata;
  logic            out_valid_next;
  logic            out_last_next;

  function automatic logic [KW-1:0] low_pin(input grp_bits_t v);
    logic [KW-1:0] idx;
    idx = '0;
    for (int i = PINS_PER_GROUP - 1; i >= 0; i--) begin
      if (v[i]) idx = KW'(i);
    end
    return idx;
  endfunction

  function automatic logic [GW-1:0] low_grp(input logic [NUM_GROUPS-1:0] v);
    logic [GW-1:0] idx;
    idx = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (v[i]) idx = GW'(i);
    end
    return idx;
  endfunction

  // per-group enable slices; pins beyond the enable register stay disabled
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_en
    for (genvar k = 0; k < PINS_PER_GROUP; k++) begin : g_bit
      if (g * PINS_PER_GROUP + k < ENABLE_W) begin : g_in
        assign en_grp[g][k] = enable_mask[g * PINS_PER_GROUP + k];
      end else begin : g_out
        assign en_grp[g][k] = 1'b0;
      end
    end
  end

  for (genvar k = 0; k < PINS_PER_GROUP; k++) begin : g_lv
    if (k < LEVELS_W) begin : g_in
      assign new_lv[k] = head.entry.levels[k];
    end else begin : g_out
      assign new_lv[k] = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_any[g] = |pending[g];
      later[g]     = group_any[g] && (GW'(g) > cur_g);
    end
  end

  assign rd_g     = (state == ST_SERVICE) ? cur_g : head.entry.grp[GW-1:0];
  assign sel_pend = pending[rd_g];
  assign sel_lv   = last_lv[rd_g];
  assign sel_en   = en_grp[rd_g];
  assign pin_k    = low_pin(sel_pend);
  assign rest     = sel_pend & ~(PINS_PER_GROUP'(1) << pin_k);
  assign pin_num  = NUM_W'(cur_g) * NUM_W'(PINS_PER_GROUP) + NUM_W'(pin_k);

  always_comb begin
    state_next     = state;
    cur_g_next     = cur_g;
    pop            = 1'b0;
    pend_we        = 1'b0;
    lv_we          = 1'b0;
    pend_wdata     = sel_pend;
    lv_wdata       = new_lv;
    out_valid_next = 1'b0;
    out_last_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.entry.op)
            OP_SAMPLE: begin
              pend_we    = 1'b1;
              pend_wdata = sel_pend | ((new_lv ^ sel_lv) & sel_en);
              lv_we      = 1'b1;
            end
            OP_CAPTURE: lv_we = 1'b1;
            OP_SERVICE: begin
              if (|group_any) begin
                cur_g_next = low_grp(group_any);
                state_next = ST_SERVICE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SERVICE: begin
        pend_we        = 1'b1;
        pend_wdata     = rest;
        out_valid_next = 1'b1;
        out_last_next  = (rest == '0) && (later == '0);
        if (out_last_next) begin
          state_next = ST_IDLE;
        end else if (rest == '0) begin
          cur_g_next = low_grp(later);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_g        <= '0;
      result_valid <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        pending[g] <= '0;
        last_lv[g] <= '0;
      end
    end else begin
      state        <= state_next;
      cur_g        <= cur_g_next;
      result_valid <= out_valid_next;
      if (pend_we) pending[rd_g] <= pend_wdata;
      if (lv_we)   last_lv[rd_g] <= lv_wdata;
    end
  end

  always_ff @(posedge clk) begin
    result.dispatched_pin <= PIN_W'(pin_num);
    result.last_of_run    <= out_last_next;
  end

  `PCID_ASSERT_SAME(a_svc_grp_pending, state == ST_SERVICE, group_any[cur_g],
    "service scan on a group with nothing pending")
  `PCID_ASSERT_SAME(a_last_ends_run, result_valid && result.last_of_run,
    state == ST_IDLE, "run did not end on its last dispatched pin")
  `PCID_ASSERT_SAME(a_mid_run_busy, result_valid && !result.last_of_run,
    state == ST_SERVICE, "run ended before its last dispatched pin")
  `PCID_ASSERT_NEXT(a_emit_in_service, state == ST_SERVICE, result_valid,
    "service cycle without a dispatched pin")

endmodule

// ----- hdl/pin_change_interrupt_dispatcher.sv -----
// ---------------------------------------------------------------------------
// pin_change_interrupt_dispatcher
// Pin-change detection over groups of pins with a scanning dispatcher.
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; busy
// rises only when the command queue (QUEUE_DEPTH entries) is full. A service
// command dispatches one pending pin per cycle, lowest pin first, the pace
// set by the priority encoder over one group of pending flags; a service
// with nothing pending produces no result. Each dispatched pin is shown on
// result for exactly one cycle with result_valid high; the receiver cannot
// stall, so it must take every result as it appears. Unused commands, and
// sample or capture commands for groups out of range, are dropped at the
// front end.
module pin_change_interrupt_dispatcher #(
  parameter int PINS_PER_GROUP = pcid_pkg::DEF_PINS_PER_GROUP,
  parameter int NUM_GROUPS     = pcid_pkg::DEF_NUM_GROUPS,
  parameter int QUEUE_DEPTH    = pcid_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pcid_pkg::in_item_t            item,
  input  logic                          cfg_write_en,
  input  logic [pcid_pkg::ENABLE_W-1:0] cfg_write_data,
  output logic                          result_valid,
  output pcid_pkg::out_item_t           result
);
  import pcid_pkg::*;

  logic [ENABLE_W-1:0] enable_mask;
  push_req_t           push_req;
  q_head_t             head;
  logic                full;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (cfg_write_en) begin
      enable_mask <= cfg_write_data;
    end
  end

  pcid_front #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_front (
    .start    (start),
    .item     (item),
    .full     (full),
    .busy     (busy),
    .push_req (push_req)
  );

  pcid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  pcid_back #(
    .PINS_PER_GROUP (PINS_PER_GROUP),
    .NUM_GROUPS     (NUM_GROUPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .enable_mask  (enable_mask),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// Pin-change interrupt dispatcher testbench
// Feeds sample, capture, service and unused commands via start/busy, mostly
// with random gaps, rewrites the pin enable mask between phases, and checks
// every dispatched pin against a model of the change flags kept in step here.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pcid_pkg::*;

  localparam int          GROUPS       = DEF_NUM_GROUPS;
  localparam int          GROUP_PINS   = DEF_PINS_PER_GROUP;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          SETTLE       = 40;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 32;
  localparam int          REPORT_LIMIT = 10;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic                busy;
  in_item_t            item_bus       = '0;
  logic                cfg_write_en   = 1'b0;
  logic [ENABLE_W-1:0] cfg_write_data = '0;
  logic                result_valid;
  out_item_t           result;

  in_item_t            command_backlog[$];
  out_item_t           dispatch_expected[$];
  logic [ENABLE_W-1:0] enable_mask = '0;
  logic [LEVELS_W-1:0] seen_levels[GROUPS];
  logic [LEVELS_W-1:0] change_flags[GROUPS];
  bit                  gaps_on = 1'b1;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  pin_change_interrupt_dispatcher i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item_bus),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result_valid   (result_valid),
    .result         (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void update_flags(in_item_t c);
    int        g;
    int        n;
    out_item_t r;
    n = 0;
    case (c.cmd)
      CMD_SAMPLE, CMD_CAPTURE: begin
        if (c.group < GROUPS) begin
          g = c.group;
          if (c.cmd == CMD_SAMPLE)
            change_flags[g] |= (c.pin_levels ^ seen_levels[g])
                               & enable_mask[g*GROUP_PINS +: GROUP_PINS];
          seen_levels[g] = c.pin_levels;
        end
      end
      CMD_SERVICE: begin
        for (int gi = 0; gi < GROUPS; gi++) begin
          for (int k = 0; k < GROUP_PINS; k++) begin
            if (change_flags[gi][k]) begin
              r.dispatched_pin = PIN_W'(gi * GROUP_PINS + k);
              r.last_of_run    = 1'b0;
              dispatch_expected.push_back(r);
              n++;
            end
          end
          change_flags[gi] = '0;
        end
        if (n > 0)
          dispatch_expected[dispatch_expected.size()-1].last_of_run = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch %0d at cycle %0d: %s", mismatches, cycle_count, msg);
  endtask

  // driver: takes the next command off the backlog, holds it while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        update_flags(item_bus);
      if (!start || !busy) begin
        if (command_backlog.size() > 0 && !(gaps_on && $urandom_range(99) < 14)) begin
          start    <= 1'b1;
          item_bus <= command_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result must match the oldest expected dispatch
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid) begin
      if (dispatch_expected.size() == 0) begin
        note_failure($sformatf("unexpected result pin %0d last %0b",
                               result.dispatched_pin, result.last_of_run));
      end else begin
        want = dispatch_expected.pop_front();
        if (result.dispatched_pin !== want.dispatched_pin ||
            result.last_of_run !== want.last_of_run)
          note_failure($sformatf("expected pin %0d last %0b, got pin %0d last %0b",
                                 want.dispatched_pin, want.last_of_run,
                                 result.dispatched_pin, result.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t make_command(logic [1:0] c, logic [1:0] g,
                                            logic [LEVELS_W-1:0] l);
    in_item_t t;
    t.cmd        = c;
    t.group      = g;
    t.pin_levels = l;
    return t;
  endfunction

  function automatic in_item_t random_command();
    int          pick;
    logic [1:0]  c;
    logic [1:0]  g;
    pick = $urandom_range(99);
    if (pick < 48)      c = CMD_SAMPLE;
    else if (pick < 66) c = CMD_SERVICE;
    else if (pick < 84) c = CMD_CAPTURE;
    else                c = CMD_UNUSED;
    g = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(GROUPS - 1));
    return make_command(c, g, LEVELS_W'($urandom));
  endfunction

  task automatic wait_drained();
    while (command_backlog.size() != 0 || start || dispatch_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable_mask(logic [ENABLE_W-1:0] v);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    enable_mask     = v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin
    logic [ENABLE_W-1:0] phase_mask;
    for (int g = 0; g < GROUPS; g++) begin
      seen_levels[g]  = '0;
      change_flags[g] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset mask is zero: a change is stored but not flagged
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd0, 8'hFF));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd0, 8'h00));
    wait_drained();

    write_enable_mask(24'hFFFFFF);
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd0, 8'h00));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd1, 8'hFF));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd2, 8'hA5));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd0, 8'h00));
    command_backlog.push_back(make_command(CMD_CAPTURE, 2'd1, 8'h00));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd1, 8'h00));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd2, 8'h3C));
    command_backlog.push_back(make_command(CMD_UNUSED, 2'd0, 8'hFF));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd3, 8'hFF));
    command_backlog.push_back(make_command(CMD_CAPTURE, 2'd3, 8'h55));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd3, 8'hFF));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd2, 8'h5A));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd0, 8'h80));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd1, 8'h00));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd1, 8'h0F));
    wait_drained();

    // flags already raised survive the mask being cleared
    write_enable_mask(24'h000000);
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd2, 8'hFF));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd0, 8'h00));
    wait_drained();

    write_enable_mask(24'h000001);
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd0, 8'h7F));
    command_backlog.push_back(make_command(CMD_SAMPLE, 2'd2, 8'h00));
    command_backlog.push_back(make_command(CMD_SERVICE, 2'd0, 8'h00));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       phase_mask = 24'hFFFFFF;
        1:       phase_mask = ENABLE_W'($urandom);
        2:       phase_mask = ENABLE_W'($urandom & $urandom);
        3:       phase_mask = 24'h000000;
        default: phase_mask = ENABLE_W'($urandom | $urandom);
      endcase
      gaps_on = (p != 2);
      write_enable_mask(phase_mask);
      for (int i = 0; i < PHASE_ITEMS; i++)
        command_backlog.push_back(random_command());
      command_backlog.push_back(make_command(CMD_SERVICE, 2'($urandom), 8'($urandom)));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- pin_change_interrupt_dispatcher.f -----
+incdir+hdl
hdl/pcid_pkg.sv
hdl/pcid_front.sv
hdl/pcid_queue.sv
hdl/pcid_back.sv
hdl/pin_change_interrupt_dispatcher.sv
verif/testbench.sv
